[rtl/assert_macros.svh]
// Assertion macros for the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk outside reset.
`define T2I_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge of clk, reset cycles included.
`define T2I_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/t2i_pkg.sv]
// Types, constants and helpers of the text-to-integer parser.
package t2i_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_CHARS_DEF  = 255;

  localparam int BASE_W  = 6;
  localparam int CHAR_W  = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_VALUE_W = 32;
  localparam int OUT_POS_W   = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SELECT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 4'd1;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CHAR_W-1:0] DIGIT_NONE = 8'hff;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_AFTER_PLUS,
    PH_ZERO,
    PH_HEX_FIRST,
    PH_DIGITS,
    PH_DONE
  } t2i_phase_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Letters map upward from ten with no upper bound; the base check rejects them.
  function automatic logic [CHAR_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    if (c >= CH_LC_A) begin
      d = c - CH_LC_A + 8'd10;
    end else if (c >= CH_UC_A) begin
      d = c - CH_UC_A + 8'd10;
    end else if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

endpackage

[rtl/text_to_integer_parser_core.sv]
// Streaming strtol/strtoul parser: one character per beat, one result per string.
// The result of a string is registered: valid in the cycle after its zero byte is accepted.
// Throughput: one character per cycle while in_stall is low; the accumulator multiply-add sets the cycle.
// A result waiting in the output register stalls input only while out_stall is high.
// Reset (rst, synchronous): parse state cleared, base_select 0, signed_mode 1.
// Parse state also returns to its reset value after each zero byte.
`include "assert_macros.svh"

module text_to_integer_parser_core
  import t2i_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_CHARS  = MAX_CHARS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAR_W-1:0]      character,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_VALUE_W-1:0] value,
  output logic                   overflowed,
  output logic [OUT_POS_W-1:0]   end_position
);

  localparam int IW = $clog2(MAX_CHARS + 1);
  localparam int VB = VALUE_BITS;
  localparam logic [IW-1:0] MAX_IDX = IW'(MAX_CHARS);
  localparam logic [VB-1:0] LIM_POS = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] LIM_NEG = {1'b1, {(VB-1){1'b0}}};

  logic [BASE_W-1:0] base_select;
  logic              signed_mode;

  t2i_phase_t        phase, phase_next;
  logic [VB-1:0]     acc, acc_next;
  logic              negative_seen, negative_seen_next;
  logic              wrap_seen, wrap_seen_next;
  logic [BASE_W-1:0] active_base, active_base_next;
  logic [IW-1:0]     char_index, char_index_next;
  logic [IW-1:0]     stop_index, stop_index_next;

  logic              in_accept;
  logic              is_end;
  logic [IW-1:0]     idx_after;
  logic [CHAR_W-1:0] digit;
  logic              starting;
  logic              zero_prefix;
  logic [BASE_W-1:0] start_base;
  logic [BASE_W-1:0] step_base;
  logic              digit_ok;
  logic [VB+5:0]     prod;
  logic [VB+6:0]     sum;
  logic              step_wraps;

  logic [VB-1:0]     res_mag;
  logic [VB-1:0]     res_val;
  logic              res_ovf;
  logic [VB+OUT_VALUE_W-1:0] res_wide;
  logic [IW+OUT_POS_W-1:0]   pos_wide;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign is_end    = (character == CH_NUL);

  assign idx_after = (char_index == MAX_IDX) ? MAX_IDX : char_index + 1'b1;
  assign digit     = digit_of(character);

  // A number starts after a plus, or in the lead phase on a byte that is not space or a taken sign.
  assign starting = (phase == PH_AFTER_PLUS) ||
                    ((phase == PH_LEAD) && !is_space(character) &&
                     !((character == CH_MINUS) && signed_mode && !negative_seen) &&
                     (character != CH_PLUS));
  assign zero_prefix = ((base_select == BASE_AUTO) || (base_select == BASE_HEX)) &&
                       (character == CH_0);
  assign start_base  = (base_select == BASE_AUTO) ? BASE_DEC : base_select;
  assign step_base   = starting ? start_base : active_base;
  assign digit_ok    = digit < CHAR_W'(step_base);

  // acc * base + d exceeds the value range exactly when the upper bits are set
  assign prod       = (VB+6)'(acc) * (VB+6)'(step_base);
  assign sum        = (VB+7)'(prod) + (VB+7)'(digit);
  assign step_wraps = |sum[VB+6:VB];

  always_comb begin
    phase_next         = phase;
    acc_next           = acc;
    negative_seen_next = negative_seen;
    wrap_seen_next     = wrap_seen;
    active_base_next   = active_base;
    stop_index_next    = stop_index;
    char_index_next    = idx_after;

    if (starting) begin
      active_base_next = zero_prefix
                         ? ((base_select == BASE_AUTO) ? BASE_OCT : BASE_HEX)
                         : start_base;
    end

    unique case (phase)
      PH_LEAD: begin
        if (is_space(character)) begin
          // skip
        end else if ((character == CH_MINUS) && signed_mode && !negative_seen) begin
          negative_seen_next = 1'b1;
        end else if (character == CH_PLUS) begin
          phase_next = PH_AFTER_PLUS;
        end
      end
      PH_ZERO: begin
        if ((character == CH_LC_X) || (character == CH_UC_X)) begin
          active_base_next = BASE_HEX;
          phase_next       = PH_HEX_FIRST;
        end
      end
      default: begin
      end
    endcase

    // Shared digit step: number start, after the zero, the first hex digit and the digit run
    if ((starting && !zero_prefix) ||
        ((phase == PH_ZERO) && (character != CH_LC_X) && (character != CH_UC_X)) ||
        (phase == PH_HEX_FIRST) || (phase == PH_DIGITS)) begin
      if (digit_ok) begin
        if (!wrap_seen) begin
          if (step_wraps) begin
            wrap_seen_next = 1'b1;
          end else begin
            acc_next = sum[VB-1:0];
          end
        end
        stop_index_next = idx_after;
        phase_next      = PH_DIGITS;
      end else begin
        phase_next = PH_DONE;
      end
    end else if (starting && zero_prefix) begin
      acc_next        = '0;
      stop_index_next = idx_after;
      phase_next      = PH_ZERO;
    end
  end

  // Saturate and sign the accumulated magnitude at the end of the string
  always_comb begin
    res_mag = acc;
    res_ovf = 1'b0;
    if (signed_mode) begin
      if (negative_seen) begin
        if (wrap_seen || (acc > LIM_NEG)) begin
          res_mag = LIM_NEG;
          res_ovf = 1'b1;
        end
        res_val = -res_mag;
      end else begin
        if (wrap_seen || (acc > LIM_POS)) begin
          res_mag = LIM_POS;
          res_ovf = 1'b1;
        end
        res_val = res_mag;
      end
    end else if (wrap_seen) begin
      res_val = '1;
      res_ovf = 1'b1;
    end else begin
      res_val = acc;
    end
  end

  assign res_wide = {{OUT_VALUE_W{1'b0}}, res_val};
  assign pos_wide = {{OUT_POS_W{1'b0}}, stop_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= BASE_AUTO;
      signed_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_SELECT: base_select <= cfg_data[BASE_W-1:0];
        REG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      acc           <= '0;
      negative_seen <= 1'b0;
      wrap_seen     <= 1'b0;
      active_base   <= '0;
      char_index    <= '0;
      stop_index    <= '0;
    end else if (in_accept) begin
      if (is_end) begin
        phase         <= PH_LEAD;
        acc           <= '0;
        negative_seen <= 1'b0;
        wrap_seen     <= 1'b0;
        active_base   <= '0;
        char_index    <= '0;
        stop_index    <= '0;
      end else begin
        phase         <= phase_next;
        acc           <= acc_next;
        negative_seen <= negative_seen_next;
        wrap_seen     <= wrap_seen_next;
        active_base   <= active_base_next;
        char_index    <= char_index_next;
        stop_index    <= stop_index_next;
      end
    end
  end

  // Result register: load on the zero byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && is_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && is_end) begin
      value        <= res_wide[OUT_VALUE_W-1:0];
      overflowed   <= res_ovf;
      end_position <= pos_wide[OUT_POS_W-1:0];
    end
  end

  `T2I_ASSERT(a_end_gives_result, in_accept && is_end |=> out_valid, "zero byte gave no result")
  `T2I_ASSERT(a_no_spurious_result, in_accept && !is_end && !in_stall && !(out_valid && out_stall) |=> !out_valid, "result without zero byte")
  `T2I_ASSERT(a_lead_is_clear, phase == PH_LEAD |-> acc == '0 && !wrap_seen && stop_index == '0, "lead phase holds stale parse state")
  `T2I_ASSERT(a_digits_have_stop, phase == PH_DIGITS |-> stop_index != '0, "digit run without stop position")
  `T2I_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")

endmodule
